// ===== design/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID steering controller package
// Shared widths, register indexes, reset values, the multiplier request and the divider status.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int TICK_WIDTH = 16;
  localparam logic [15:0] TICK_MASK = 16'((64'd1 << TICK_WIDTH) - 64'd1);

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_W   = 50;
  localparam int DIVS_W  = 16;
  localparam int DIVC_W  = $clog2(DIV_W + 1);

  localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_BOUND = 3'd3;
  localparam logic [2:0] REG_DRIVE_UPPER    = 3'd4;
  localparam logic [2:0] REG_DRIVE_LOWER    = 3'd5;
  localparam logic [2:0] REG_TRIM_OFFSET    = 3'd6;
  localparam logic [2:0] REG_TICK_RATE      = 3'd7;

  localparam logic [23:0] RST_PROP_GAIN      = 24'd301990;
  localparam logic [23:0] RST_INTEG_GAIN     = 24'd335544;
  localparam logic [23:0] RST_DERIV_GAIN     = 24'd5033;
  localparam logic [18:0] RST_INTEGRAL_BOUND = 19'd65536;
  localparam logic [15:0] RST_DRIVE_UPPER    = 16'd18022;
  localparam logic [15:0] RST_DRIVE_LOWER    = 16'hC666;
  localparam logic [15:0] RST_TRIM_OFFSET    = 16'hF9BA;
  localparam logic [15:0] RST_TICK_RATE      = 16'd10000;

  typedef struct packed {
    logic               issue;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/pid_steering_controller.sv =====
// ----------------------------------------------------------------------------
// PID steering controller
// Fixed-point PID with anti-windup guard, built on one multiplier and one
// iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one request per
// control step: measured_pos, target_pos and elapsed_ticks. The output
// channel (out_valid / out_stall) returns one request per step: steer_cmd
// in Q1.15 plus the drive_clamped, integral_clamped and zero_interval flags.
// Gains, limits, trim and tick rate are written through cfg_we, cfg_index
// and cfg_data only while the block is idle: the user is bound to this, the
// block itself does not enforce it. A step runs through two passes of the
// restoring divider (the integral increment and the derivative) and the
// sequencer states around them; a zero interval skips the second pass.
// One step is worked on at a time: in_stall is high from acceptance until
// the result is in the output register, and only then can the next request
// be taken.
// The output register holds its result while out_stall is high; a new
// request can be accepted meanwhile, but its result waits for the held one.
// Synchronous reset loads the register reset values and clears the
// integral, the previous error and the previous drive.
// ----------------------------------------------------------------------------
module pid_steering_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] measured_pos,
  input  logic signed [7:0] target_pos,
  input  logic [15:0]       elapsed_ticks,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] steer_cmd,
  output logic              drive_clamped,
  output logic              integral_clamped,
  output logic              zero_interval,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_ET = 4'd1;
  localparam logic [3:0] S_MUL_P  = 4'd2;
  localparam logic [3:0] S_DIV_I  = 4'd3;
  localparam logic [3:0] S_INTEG  = 4'd4;
  localparam logic [3:0] S_MUL_I  = 4'd5;
  localparam logic [3:0] S_MUL_D1 = 4'd6;
  localparam logic [3:0] S_MUL_D2 = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DWAIT  = 4'd9;
  localparam logic [3:0] S_SUM    = 4'd10;
  localparam logic [3:0] S_ROUND  = 4'd11;

  // Configuration registers.
  logic [23:0]        prop_gain, integ_gain, deriv_gain;
  logic [18:0]        integral_bound;
  logic signed [15:0] drive_upper, drive_lower, trim_offset;
  logic [15:0]        tick_rate;

  // Controller state.
  logic signed [19:0] integ_acc;
  logic signed [8:0]  last_error;
  logic signed [15:0] last_drive;

  // Per-step working registers.
  logic [3:0]         state;
  logic signed [8:0]  err;
  logic signed [9:0]  derr;
  logic [15:0]        ticks;
  logic [15:0]        rate;
  logic               zero;
  logic               guard;
  logic               iclamp;
  logic [32:0]        p_mag;
  logic [27:0]        i_mag;
  logic [49:0]        d_mag;
  logic signed [51:0] sum;

  psc_pkg::mul_req_t                    mreq;
  logic [psc_pkg::MUL_P_W-1:0]          prod;
  logic                                 dstart;
  logic [psc_pkg::DIV_W-1:0]            dividend;
  logic [psc_pkg::DIVS_W-1:0]           divisor;
  psc_pkg::div_stat_t                   dstat;
  logic [psc_pkg::DIV_W-1:0]            quot;

  psc_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  psc_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dividend),
    .divisor(divisor), .stat(dstat), .quotient(quot)
  );

  logic               in_take;
  logic               res_load;
  logic signed [8:0]  err_in;
  logic signed [16:0] abs_drive;
  logic [8:0]         err_mag;
  logic [9:0]         derr_mag;
  logic [19:0]        integ_mag;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  // The finished step moves into the output register once it is free.
  assign res_load = (state == S_ROUND) && !(out_valid && out_stall);
  assign err_in   = 9'(target_pos) - 9'(measured_pos);
  assign abs_drive = last_drive[15] ? -17'(last_drive) : 17'(last_drive);
  assign err_mag   = err[8] ? -err : err;
  assign derr_mag  = derr[9] ? -derr : derr;
  assign integ_mag = integ_acc[19] ? -integ_acc : integ_acc;

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mreq     = '0;
    dstart   = 1'b0;
    dividend = '0;
    divisor  = ticks;
    unique case (state)
      S_MUL_ET: begin
        mreq.issue = 1'b1;
        mreq.a     = 33'(err_mag);
        mreq.b     = 24'(ticks);
      end
      S_MUL_P: begin
        mreq.issue = 1'b1;
        mreq.a     = 33'(err_mag);
        mreq.b     = prop_gain;
        dstart     = 1'b1;
        dividend   = {10'd0, prod[23:0], 16'd0};
        divisor    = rate;
      end
      S_MUL_I: begin
        mreq.issue = 1'b1;
        mreq.a     = 33'(integ_mag);
        mreq.b     = integ_gain;
      end
      S_MUL_D1: begin
        mreq.issue = 1'b1;
        mreq.a     = 33'(derr_mag);
        mreq.b     = deriv_gain;
      end
      S_MUL_D2: begin
        mreq.issue = 1'b1;
        mreq.a     = prod[32:0];
        mreq.b     = 24'(rate);
      end
      S_DSTART: begin
        dstart   = !zero;
        dividend = prod[49:0];
        divisor  = ticks;
      end
      default: begin
        mreq   = '0;
        dstart = 1'b0;
      end
    endcase
  end

  // Integral update with windup guard and symmetric clamp.
  logic signed [51:0] inc_s;
  logic signed [51:0] integ_new;
  logic signed [51:0] bound_s;

  assign inc_s     = err[8] ? -52'(quot[40:0]) : 52'(quot[40:0]);
  assign bound_s   = 52'(integral_bound);
  assign integ_new = 52'(integ_acc) + (guard ? inc_s : 52'sd0);

  // Rounding and output clamps.
  logic [51:0]        sum_mag;
  logic [42:0]        rnd_mag;
  logic signed [43:0] drive_w;
  logic signed [15:0] drive_c;
  logic               dclamp;
  logic signed [16:0] cmd_w;
  logic signed [15:0] cmd_s;

  assign sum_mag = sum[51] ? -sum : sum;
  assign rnd_mag = 43'((sum_mag + 52'd256) >> 9);
  assign drive_w = sum[51] ? -44'(rnd_mag) : 44'(rnd_mag);

  always_comb begin
    dclamp  = 1'b1;
    drive_c = drive_w[15:0];
    priority if (drive_w > 44'(drive_upper)) begin
      drive_c = drive_upper;
    end else if (drive_w < 44'(drive_lower)) begin
      drive_c = drive_lower;
    end else begin
      dclamp = 1'b0;
    end
  end

  assign cmd_w = 17'(trim_offset) - 17'(drive_c);

  always_comb begin
    priority if (cmd_w > 17'sd32767) begin
      cmd_s = 16'sh7FFF;
    end else if (cmd_w < -17'sd32768) begin
      cmd_s = 16'sh8000;
    end else begin
      cmd_s = cmd_w[15:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= psc_pkg::RST_PROP_GAIN;
      integ_gain     <= psc_pkg::RST_INTEG_GAIN;
      deriv_gain     <= psc_pkg::RST_DERIV_GAIN;
      integral_bound <= psc_pkg::RST_INTEGRAL_BOUND;
      drive_upper    <= psc_pkg::RST_DRIVE_UPPER;
      drive_lower    <= psc_pkg::RST_DRIVE_LOWER;
      trim_offset    <= psc_pkg::RST_TRIM_OFFSET;
      tick_rate      <= psc_pkg::RST_TICK_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psc_pkg::REG_PROP_GAIN:      prop_gain      <= cfg_data;
        psc_pkg::REG_INTEG_GAIN:     integ_gain     <= cfg_data;
        psc_pkg::REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
        psc_pkg::REG_INTEGRAL_BOUND: integral_bound <= cfg_data[18:0];
        psc_pkg::REG_DRIVE_UPPER:    drive_upper    <= cfg_data[15:0];
        psc_pkg::REG_DRIVE_LOWER:    drive_lower    <= cfg_data[15:0];
        psc_pkg::REG_TRIM_OFFSET:    trim_offset    <= cfg_data[15:0];
        psc_pkg::REG_TICK_RATE:      tick_rate      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      integ_acc  <= '0;
      last_error <= '0;
      last_drive <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_MUL_ET;
          end
        end
        S_MUL_ET: state <= S_MUL_P;
        S_MUL_P:  state <= S_DIV_I;
        S_DIV_I: begin
          if (dstat.done) begin
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          priority if (integ_new > bound_s) begin
            integ_acc <= 20'(integral_bound);
          end else if (integ_new < -bound_s) begin
            integ_acc <= -20'(integral_bound);
          end else begin
            integ_acc <= integ_new[19:0];
          end
          state <= S_MUL_I;
        end
        S_MUL_I:  state <= S_MUL_D1;
        S_MUL_D1: state <= S_MUL_D2;
        S_MUL_D2: state <= S_DSTART;
        S_DSTART: state <= zero ? S_SUM : S_DWAIT;
        S_DWAIT: begin
          if (dstat.done) begin
            state <= S_SUM;
          end
        end
        S_SUM: state <= S_ROUND;
        S_ROUND: begin
          if (res_load) begin
            last_error <= err;
            last_drive <= drive_c;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      err   <= err_in;
      derr  <= 10'(err_in) - 10'(last_error);
      ticks <= elapsed_ticks & psc_pkg::TICK_MASK;
      rate  <= (tick_rate == 16'd0) ? 16'd1 : tick_rate;
      zero  <= (elapsed_ticks & psc_pkg::TICK_MASK) == 16'd0;
      guard <= abs_drive < 17'(drive_upper);
    end
    if (state == S_DIV_I && dstat.done) begin
      p_mag <= prod[32:0];
    end
    if (state == S_INTEG) begin
      iclamp <= (integ_new > bound_s) || (integ_new < -bound_s);
    end
    if (state == S_MUL_D1) begin
      i_mag <= prod[43:16];
    end
    if (state == S_DSTART) begin
      d_mag <= '0;
    end else if (state == S_DWAIT && dstat.done) begin
      d_mag <= quot;
    end
    if (state == S_SUM) begin
      sum <= (err[8] ? -52'(p_mag) : 52'(p_mag))
           + (integ_acc[19] ? -52'(i_mag) : 52'(i_mag))
           + (derr[9] ? -52'(d_mag) : 52'(d_mag));
    end
    if (res_load) begin
      steer_cmd        <= cmd_s;
      drive_clamped    <= dclamp;
      integral_clamped <= iclamp;
      zero_interval    <= zero;
    end
  end

  // The divider is never left running once the sequencer is back at rest.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !dstat.busy)
    else $error("divider busy while sequencer idle");

  // An accepted request always starts the sequencer.
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_MUL_ET)
    else $error("accepted request did not start a step");

  // A new result only appears from the final sequencer step.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_ROUND)
    else $error("result raised outside the final step");

  // A zero interval never runs the derivative division.
  a_zero_nodiv: assert property (@(posedge clk) disable iff (rst)
    state == S_DSTART && zero |-> !dstart)
    else $error("divider started on a zero interval");

endmodule

// ===== design/psc_mul.sv =====
// ----------------------------------------------------------------------------
// PID steering controller shared multiplier
// Unsigned multiply with a registered product, loaded on each issue.
// ----------------------------------------------------------------------------
module psc_mul (
  input  logic                     clk,
  input  psc_pkg::mul_req_t        req,
  output logic [psc_pkg::MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod <= psc_pkg::MUL_P_W'(req.a) * psc_pkg::MUL_P_W'(req.b);
    end
  end

endmodule

// ===== design/psc_div.sv =====
// ----------------------------------------------------------------------------
// PID steering controller shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [psc_pkg::DIV_W-1:0]    dividend,
  input  logic [psc_pkg::DIVS_W-1:0]   divisor,
  output psc_pkg::div_stat_t           stat,
  output logic [psc_pkg::DIV_W-1:0]    quotient
);

  logic [psc_pkg::DIVS_W-1:0] rem;
  logic [psc_pkg::DIVS_W-1:0] dsr;
  logic [psc_pkg::DIVC_W-1:0] cnt;
  logic [psc_pkg::DIVS_W:0]   trial;
  logic                       fits;

  assign trial = {rem, quotient[psc_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= psc_pkg::DIVC_W'(psc_pkg::DIV_W);
    end else if (stat.busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == psc_pkg::DIVC_W'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (stat.busy) begin
      quotient <= {quotient[psc_pkg::DIV_W-2:0], fits};
      rem      <= fits ? psc_pkg::DIVS_W'(trial - {1'b0, dsr})
                       : psc_pkg::DIVS_W'(trial);
    end
  end

endmodule

// ===== verif/pid_steering_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID steering controller testbench
// Drives control-step requests with random gaps, applies back-pressure on the
// result side, and compares every result against a fixed-point PID predictor
// kept inside a small scoreboard class. Gains and limits change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module pid_steering_controller_tb;

  typedef struct packed {
    logic signed [15:0] steer;
    logic               dclamp;
    logic               iclamp;
    logic               zint;
  } steer_result_t;

  // Scoreboard: holds a copy of the controller state and registers, predicts
  // the result of each accepted request and checks results in order.
  class steer_scoreboard;
    logic [23:0]        kp, ki, kd;
    logic [18:0]        ibound;
    logic signed [15:0] upper, lower, trim;
    logic [15:0]        rate_reg;
    longint             integ_acc, prev_err, prev_drive;
    steer_result_t      pending[$];
    int                 mismatches;

    function void reset_state();
      kp = psc_pkg::RST_PROP_GAIN; ki = psc_pkg::RST_INTEG_GAIN;
      kd = psc_pkg::RST_DERIV_GAIN;
      ibound = psc_pkg::RST_INTEGRAL_BOUND;
      upper = psc_pkg::RST_DRIVE_UPPER; lower = psc_pkg::RST_DRIVE_LOWER;
      trim = psc_pkg::RST_TRIM_OFFSET;
      rate_reg = psc_pkg::RST_TICK_RATE;
      integ_acc = 0; prev_err = 0; prev_drive = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        psc_pkg::REG_PROP_GAIN:      kp = val;
        psc_pkg::REG_INTEG_GAIN:     ki = val;
        psc_pkg::REG_DERIV_GAIN:     kd = val;
        psc_pkg::REG_INTEGRAL_BOUND: ibound = val[18:0];
        psc_pkg::REG_DRIVE_UPPER:    upper = val[15:0];
        psc_pkg::REG_DRIVE_LOWER:    lower = val[15:0];
        psc_pkg::REG_TRIM_OFFSET:    trim = val[15:0];
        psc_pkg::REG_TICK_RATE:      rate_reg = val[15:0];
        default: ;
      endcase
    endfunction

    // Note an accepted request and queue the result it should produce.
    function void note_request(logic signed [7:0] meas, logic signed [7:0] tgt,
                               logic [15:0] ticks_in);
      longint ticks, rate, err, integ, bnd, absd, p, i, d, sum, mag, drive, cmd;
      steer_result_t r;
      ticks = ticks_in & psc_pkg::TICK_MASK;
      rate = (rate_reg == 0) ? 1 : rate_reg;
      err = longint'(tgt) - longint'(meas);
      integ = integ_acc;
      bnd = ibound;
      absd = (prev_drive < 0) ? -prev_drive : prev_drive;
      r = '0;
      r.zint = (ticks == 0);
      if (absd < longint'(upper)) integ += (err * ticks * 65536) / rate;
      if (integ > bnd) begin
        integ = bnd; r.iclamp = 1;
      end else if (integ < -bnd) begin
        integ = -bnd; r.iclamp = 1;
      end
      p = longint'(kp) * err;
      i = (longint'(ki) * integ) / 65536;
      d = r.zint ? 0 : (longint'(kd) * (err - prev_err) * rate) / ticks;
      sum = p + i + d;
      mag = (sum < 0) ? -sum : sum;
      mag = (mag + 256) >>> 9;
      drive = (sum < 0) ? -mag : mag;
      if (drive > longint'(upper)) begin
        drive = upper; r.dclamp = 1;
      end else if (drive < longint'(lower)) begin
        drive = lower; r.dclamp = 1;
      end
      cmd = longint'(trim) - drive;
      if (cmd > 32767) cmd = 32767;
      if (cmd < -32768) cmd = -32768;
      r.steer = cmd[15:0];
      integ_acc = integ;
      prev_err = err;
      prev_drive = drive;
      pending.push_back(r);
    endfunction

    function void check_result(steer_result_t got);
      steer_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result steer=%0d flags=%b%b%b", got.steer,
                   got.dclamp, got.iclamp, got.zint);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: steer exp %0d got %0d, dclamp %b/%b, iclamp %b/%b, zint %b/%b",
                   want.steer, got.steer, want.dclamp, got.dclamp,
                   want.iclamp, got.iclamp, want.zint, got.zint);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [7:0] measured_pos = 0;
  logic signed [7:0] target_pos = 0;
  logic [15:0] elapsed_ticks = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] steer_cmd;
  logic drive_clamped, integral_clamped, zero_interval;
  logic cfg_we = 0;
  logic [2:0] cfg_index = psc_pkg::REG_PROP_GAIN;
  logic [23:0] cfg_data = 0;

  steer_scoreboard sb;
  bit idle_enable = 1;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 4000000;

  pid_steering_controller dut (.*);

  always #5 clk = ~clk;

  // Timeout guard: a correct run with every stall is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check every accepted result at the rising edge.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result({steer_cmd, drive_clamped, integral_clamped, zero_interval});

  // Result back-pressure in random bursts of random length, while idle_enable is set.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
      @(negedge clk);
    end
  end

  // Send one request and hold it until accepted; a random gap may come first.
  // Valid stays up after acceptance so the next request can follow directly;
  // the gap and drain() drop it.
  task automatic send_step(logic signed [7:0] m, logic signed [7:0] t, logic [15:0] tk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1;
    measured_pos <= m;
    target_pos <= t;
    elapsed_ticks <= tk;
    do @(posedge clk); while (in_stall);
    sb.note_request(m, t, tk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // Wait until every expected result is back, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Random ticks: mostly control-rate intervals, sometimes zero or extreme.
  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  task automatic random_phase(int count);
    logic signed [7:0] m;
    for (int k = 0; k < count; k++) begin
      m = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40) - 20);
      send_step(m, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'sd0, pick_ticks());
    end
  endtask

  task automatic random_config();
    write_cfg(psc_pkg::REG_PROP_GAIN, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                      : 24'($urandom_range(0, 600000)));
    write_cfg(psc_pkg::REG_INTEG_GAIN, 24'($urandom));
    write_cfg(psc_pkg::REG_DERIV_GAIN, $urandom_range(0, 1) ? 24'($urandom_range(0, 20000))
                                       : 24'($urandom));
    write_cfg(psc_pkg::REG_INTEGRAL_BOUND, 24'($urandom_range(0, 524287)));
    write_cfg(psc_pkg::REG_DRIVE_UPPER, 24'($urandom_range(0, 65535)));
    write_cfg(psc_pkg::REG_DRIVE_LOWER, 24'($urandom_range(0, 65535)));
    write_cfg(psc_pkg::REG_TRIM_OFFSET, 24'($urandom_range(0, 65535)));
    write_cfg(psc_pkg::REG_TICK_RATE, 24'($urandom_range(0, 65535)));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part under reset settings: position extremes, zero interval,
    // maximum interval, and a long push so the windup guard and clamps act.
    send_step(8'sd0, 8'sd0, 16'd0);
    send_step(-8'sd128, 8'sd127, 16'd100);
    send_step(8'sd127, -8'sd128, 16'd100);
    send_step(8'sd127, -8'sd128, 16'd0);
    send_step(8'sd5, 8'sd0, 16'hFFFF);
    send_step(-8'sd128, 8'sd127, 16'hFFFF);
    for (int k = 0; k < 4; k++) send_step(8'sd10, -8'sd10, 16'd1000);
    drain();

    // Extreme settings: zero tick rate, negative upper limit, crossed limits,
    // trim that makes the command saturate, maximal gains and bound.
    write_cfg(psc_pkg::REG_TICK_RATE, 24'd0);
    write_cfg(psc_pkg::REG_DRIVE_UPPER, 24'h008000);
    write_cfg(psc_pkg::REG_DRIVE_LOWER, 24'h007FFF);
    write_cfg(psc_pkg::REG_TRIM_OFFSET, 24'h007FFF);
    write_cfg(psc_pkg::REG_PROP_GAIN, 24'hFFFFFF);
    write_cfg(psc_pkg::REG_INTEG_GAIN, 24'hFFFFFF);
    write_cfg(psc_pkg::REG_DERIV_GAIN, 24'hFFFFFF);
    write_cfg(psc_pkg::REG_INTEGRAL_BOUND, 24'h07FFFF);
    send_step(8'sd0, 8'sd1, 16'd3);
    send_step(8'sd127, -8'sd128, 16'd1);
    send_step(-8'sd128, 8'sd127, 16'd0);
    send_step(8'sd0, 8'sd0, 16'd7);
    drain();
    write_cfg(psc_pkg::REG_TRIM_OFFSET, 24'h008000);
    write_cfg(psc_pkg::REG_DRIVE_UPPER, 24'h007FFF);
    write_cfg(psc_pkg::REG_DRIVE_LOWER, 24'h008000);
    write_cfg(psc_pkg::REG_TICK_RATE, 24'h00FFFF);
    write_cfg(psc_pkg::REG_INTEGRAL_BOUND, 24'd0);
    write_cfg(psc_pkg::REG_PROP_GAIN, 24'd0);
    write_cfg(psc_pkg::REG_INTEG_GAIN, 24'd0);
    write_cfg(psc_pkg::REG_DERIV_GAIN, 24'd0);
    send_step(8'sd1, 8'sd0, 16'd5);
    send_step(-8'sd128, 8'sd127, 16'hFFFF);
    send_step(8'sd127, -8'sd128, 16'd0);
    drain();

    // Random phases, each with fresh settings; the drain before each write
    // also makes the sender pause until every result is back.
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      random_phase(110);
      drain();
    end

    // Last part: reset-like settings, no idling on either side.
    write_cfg(psc_pkg::REG_PROP_GAIN, psc_pkg::RST_PROP_GAIN);
    write_cfg(psc_pkg::REG_INTEG_GAIN, psc_pkg::RST_INTEG_GAIN);
    write_cfg(psc_pkg::REG_DERIV_GAIN, psc_pkg::RST_DERIV_GAIN);
    write_cfg(psc_pkg::REG_INTEGRAL_BOUND, 24'(psc_pkg::RST_INTEGRAL_BOUND));
    write_cfg(psc_pkg::REG_DRIVE_UPPER, 24'(psc_pkg::RST_DRIVE_UPPER));
    write_cfg(psc_pkg::REG_DRIVE_LOWER, 24'(psc_pkg::RST_DRIVE_LOWER));
    write_cfg(psc_pkg::REG_TRIM_OFFSET, 24'(psc_pkg::RST_TRIM_OFFSET));
    write_cfg(psc_pkg::REG_TICK_RATE, 24'(psc_pkg::RST_TICK_RATE));
    idle_enable = 0;
    random_phase(125);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/psc_pkg.sv
design/psc_mul.sv
design/psc_div.sv
design/pid_steering_controller.sv
verif/pid_steering_controller_tb.sv
